// ----- hdl/iqs_pkg.sv -----
// Shared types and constants for the iterative quicksort engine.
package iqs_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int KEY_WIDTH_DEF = 16;

    // Datapath operations, one per cycle, issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE       = 5'd0,
        OP_LOAD       = 5'd1,
        OP_INIT_PUSH  = 5'd2,
        OP_POP        = 5'd3,
        OP_RANGE      = 5'd4,
        OP_PIVOT      = 5'd5,
        OP_LOOP_RD    = 5'd6,
        OP_SI_STEP    = 5'd7,
        OP_SJ_STEP    = 5'd8,
        OP_SWAP_A     = 5'd9,
        OP_SWAP_B     = 5'd10,
        OP_FIN_A      = 5'd11,
        OP_FIN_B      = 5'd12,
        OP_PUSH_R     = 5'd13,
        OP_PUSH_L     = 5'd14,
        OP_EMIT_START = 5'd15,
        OP_EMIT       = 5'd16
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic stk_empty;
        logic n_small;
        logic range_bad;
        logic i_le_j;
        logic j_gt_i;
        logic a_le_k;
        logic k_le_b;
        logic b_lt_k;
        logic push_r_ok;
        logic push_l_ok;
        logic out_free;
        logic emit_last;
    } t_sts;

endpackage

// ----- hdl/iqs_ctrl.sv -----
// Sequencer for loading, partitioning and emission of the quicksort engine.
module iqs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_in,
    input  iqs_pkg::t_sts i_sts,
    output iqs_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    typedef enum logic [14:0] {
        S_LOAD   = 15'h0001,
        S_INIT   = 15'h0002,
        S_POP    = 15'h0004,
        S_RANGE  = 15'h0008,
        S_PIVOT  = 15'h0010,
        S_CHECK  = 15'h0020,
        S_SCAN_I = 15'h0040,
        S_SCAN_J = 15'h0080,
        S_SWAP_A = 15'h0100,
        S_SWAP_B = 15'h0200,
        S_FIN_A  = 15'h0400,
        S_FIN_B  = 15'h0800,
        S_PUSH_R = 15'h1000,
        S_PUSH_L = 15'h2000,
        S_EMIT   = 15'h4000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = iqs_pkg::OP_NONE;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.op = iqs_pkg::OP_LOAD;
                    if (i_last_in) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                if (!i_sts.n_small) begin
                    o_cmd.op = iqs_pkg::OP_INIT_PUSH;
                end
                n_state = S_POP;
            end
            S_POP: begin
                if (i_sts.stk_empty) begin
                    o_cmd.op = iqs_pkg::OP_EMIT_START;
                    n_state  = S_EMIT;
                end else begin
                    o_cmd.op = iqs_pkg::OP_POP;
                    n_state  = S_RANGE;
                end
            end
            S_RANGE: begin
                if (i_sts.range_bad) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.op = iqs_pkg::OP_RANGE;
                    n_state  = S_PIVOT;
                end
            end
            S_PIVOT: begin
                o_cmd.op = iqs_pkg::OP_PIVOT;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.op = iqs_pkg::OP_LOOP_RD;
                n_state  = i_sts.j_gt_i ? S_SCAN_I : S_FIN_A;
            end
            S_SCAN_I: begin
                if (i_sts.i_le_j && i_sts.a_le_k) begin
                    o_cmd.op = iqs_pkg::OP_SI_STEP;
                end else begin
                    n_state = S_SCAN_J;
                end
            end
            S_SCAN_J: begin
                if (i_sts.i_le_j && i_sts.k_le_b) begin
                    o_cmd.op = iqs_pkg::OP_SJ_STEP;
                end else if (i_sts.i_le_j) begin
                    n_state = S_SWAP_A;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_SWAP_A: begin
                o_cmd.op = iqs_pkg::OP_SWAP_A;
                n_state  = S_SWAP_B;
            end
            S_SWAP_B: begin
                o_cmd.op = iqs_pkg::OP_SWAP_B;
                n_state  = S_CHECK;
            end
            S_FIN_A: begin
                // pivot goes to j only if the key there is strictly smaller
                if (i_sts.b_lt_k) begin
                    o_cmd.op = iqs_pkg::OP_FIN_A;
                    n_state  = S_FIN_B;
                end else begin
                    n_state = S_PUSH_R;
                end
            end
            S_FIN_B: begin
                o_cmd.op = iqs_pkg::OP_FIN_B;
                n_state  = S_PUSH_R;
            end
            S_PUSH_R: begin
                if (i_sts.push_r_ok) begin
                    o_cmd.op = iqs_pkg::OP_PUSH_R;
                end
                n_state = S_PUSH_L;
            end
            S_PUSH_L: begin
                if (i_sts.push_l_ok) begin
                    o_cmd.op = iqs_pkg::OP_PUSH_L;
                end
                n_state = S_POP;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = iqs_pkg::OP_EMIT;
                    if (i_sts.emit_last) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_LOAD);

endmodule

// ----- hdl/iqs_dpath.sv -----
// Key store, range stack, index registers and output register of the quicksort engine.
module iqs_dpath #(
    parameter int DEPTH     = iqs_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = iqs_pkg::KEY_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  iqs_pkg::t_cmd               i_cmd,
    input  logic signed [KEY_WIDTH-1:0] i_key_in,
    input  logic                        i_out_stall,
    output iqs_pkg::t_sts               o_sts,
    output logic                        o_out_valid,
    output logic signed [KEY_WIDTH-1:0] o_key_out,
    output logic                        o_last_out,
    output logic                        o_overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic signed [KEY_WIDTH-1:0] r_key_mem [DEPTH];
    logic        [2*AW-1:0]      r_stk_mem [DEPTH];

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [CW-1:0] r_sp;
    logic [AW-1:0] r_l;
    logic [AW-1:0] r_r;
    logic [CW-1:0] r_i;
    logic [AW-1:0] r_j;
    logic [AW-1:0] r_e;
    logic signed [KEY_WIDTH-1:0] r_k;
    logic signed [KEY_WIDTH-1:0] r_rd_a;
    logic signed [KEY_WIDTH-1:0] r_rd_b;
    logic [2*AW-1:0] r_stk_rd;

    logic                        r_out_valid;
    logic signed [KEY_WIDTH-1:0] r_out_key;
    logic                        r_out_last;
    logic                        r_out_ovf;

    logic                        we;
    logic [AW-1:0]               waddr;
    logic signed [KEY_WIDTH-1:0] wdata;
    logic                        ra_en;
    logic [AW-1:0]               ra_addr;
    logic                        rb_en;
    logic [AW-1:0]               rb_addr;
    logic                        sw_en;
    logic [AW-1:0]               sw_addr;
    logic [2*AW-1:0]             sw_data;

    logic [AW-1:0] stk_l;
    logic [AW-1:0] stk_h;
    logic [CW-1:0] n_m1;
    logic [CW-1:0] i_p1;
    logic [CW-1:0] sp_m1;
    logic          count_ok;
    logic          sp_ok;
    logic          i_le_j;
    logic          emit_last;

    assign stk_l     = r_stk_rd[AW-1:0];
    assign stk_h     = r_stk_rd[2*AW-1:AW];
    assign n_m1      = r_count - CW'(1);
    assign i_p1      = r_i + CW'(1);
    assign sp_m1     = r_sp - CW'(1);
    assign count_ok  = (r_count < CW'(DEPTH));
    assign sp_ok     = (r_sp < CW'(DEPTH));
    assign i_le_j    = (r_i <= {1'b0, r_j});
    assign emit_last = (({1'b0, r_e} + CW'(1)) == r_count);

    assign o_sts.stk_empty = (r_sp == '0);
    assign o_sts.n_small   = (r_count < CW'(2));
    assign o_sts.range_bad = ({1'b0, stk_l} >= r_count) || ({1'b0, stk_h} >= r_count)
                             || (stk_h < stk_l);
    assign o_sts.i_le_j    = i_le_j;
    assign o_sts.j_gt_i    = ({1'b0, r_j} > r_i);
    assign o_sts.a_le_k    = (r_rd_a <= r_k);
    assign o_sts.k_le_b    = (r_k <= r_rd_b);
    assign o_sts.b_lt_k    = (r_rd_b < r_k);
    assign o_sts.push_r_ok = (r_r > r_j);
    assign o_sts.push_l_ok = (r_j > r_l);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.emit_last = emit_last;

    // Memory port steering
    always_comb begin
        we      = 1'b0;
        waddr   = r_count[AW-1:0];
        wdata   = i_key_in;
        ra_en   = 1'b0;
        ra_addr = r_i[AW-1:0];
        rb_en   = 1'b0;
        rb_addr = r_j;
        sw_en   = 1'b0;
        sw_addr = r_sp[AW-1:0];
        sw_data = {r_r, r_l};
        case (i_cmd.op)
            iqs_pkg::OP_LOAD: begin
                we = count_ok;
            end
            iqs_pkg::OP_INIT_PUSH: begin
                sw_en   = sp_ok;
                sw_data = {n_m1[AW-1:0], AW'(0)};
            end
            iqs_pkg::OP_PUSH_R: begin
                sw_en   = sp_ok;
                sw_data = {r_r, r_j + AW'(1)};
            end
            iqs_pkg::OP_PUSH_L: begin
                sw_en   = sp_ok;
                sw_data = {r_j - AW'(1), r_l};
            end
            iqs_pkg::OP_RANGE: begin
                ra_en   = 1'b1;
                ra_addr = stk_l;
            end
            iqs_pkg::OP_LOOP_RD: begin
                ra_en = i_le_j;
                rb_en = 1'b1;
            end
            iqs_pkg::OP_SI_STEP: begin
                ra_en   = (i_p1 <= {1'b0, r_j});
                ra_addr = i_p1[AW-1:0];
            end
            iqs_pkg::OP_SJ_STEP: begin
                rb_en   = 1'b1;
                rb_addr = r_j - AW'(1);
            end
            iqs_pkg::OP_SWAP_A: begin
                we    = 1'b1;
                waddr = r_i[AW-1:0];
                wdata = r_rd_b;
            end
            iqs_pkg::OP_SWAP_B: begin
                we    = 1'b1;
                waddr = r_j;
                wdata = r_rd_a;
            end
            iqs_pkg::OP_FIN_A: begin
                we    = 1'b1;
                waddr = r_l;
                wdata = r_rd_b;
            end
            iqs_pkg::OP_FIN_B: begin
                we    = 1'b1;
                waddr = r_j;
                wdata = r_k;
            end
            iqs_pkg::OP_EMIT_START: begin
                ra_en   = 1'b1;
                ra_addr = '0;
            end
            iqs_pkg::OP_EMIT: begin
                ra_en   = !emit_last;
                ra_addr = r_e + AW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_key_mem[waddr] <= wdata;
        end
        if (ra_en) begin
            r_rd_a <= r_key_mem[ra_addr];
        end
        if (rb_en) begin
            r_rd_b <= r_key_mem[rb_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sw_en) begin
            r_stk_mem[sw_addr] <= sw_data;
        end
        if (i_cmd.op == iqs_pkg::OP_POP) begin
            r_stk_rd <= r_stk_mem[sp_m1[AW-1:0]];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                iqs_pkg::OP_LOAD: begin
                    if (count_ok) begin
                        r_count <= r_count + CW'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                iqs_pkg::OP_INIT_PUSH, iqs_pkg::OP_PUSH_R, iqs_pkg::OP_PUSH_L: begin
                    if (sp_ok) begin
                        r_sp <= r_sp + CW'(1);
                    end
                end
                iqs_pkg::OP_POP: begin
                    r_sp <= sp_m1;
                end
                iqs_pkg::OP_EMIT: begin
                    if (emit_last) begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_sp    <= '0;
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.op == iqs_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Indices, pivot and output payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            iqs_pkg::OP_RANGE: begin
                r_l <= stk_l;
                r_r <= stk_h;
                r_i <= {1'b0, stk_l} + CW'(1);
                r_j <= stk_h;
            end
            iqs_pkg::OP_PIVOT: begin
                r_k <= r_rd_a;
            end
            iqs_pkg::OP_SI_STEP: begin
                r_i <= i_p1;
            end
            iqs_pkg::OP_SJ_STEP: begin
                r_j <= r_j - AW'(1);
            end
            iqs_pkg::OP_EMIT_START: begin
                r_e <= '0;
            end
            iqs_pkg::OP_EMIT: begin
                r_e        <= r_e + AW'(1);
                r_out_key  <= r_rd_a;
                r_out_last <= emit_last;
                r_out_ovf  <= r_ovf;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_key_out   = r_out_key;
    assign o_last_out  = r_out_last;
    assign o_overflow  = r_out_ovf;

endmodule

// ----- hdl/iterative_quicksort_engine.sv -----
// Top level of the iterative quicksort engine: sequencer plus key store datapath.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_key_in, i_last_in
//  out     | output    | o_out_valid / i_out_stall | o_key_out, o_last_out, o_overflow
//
// Loads accept one item per cycle. After the last item the engine pushes the full range, then
// pops ranges and partitions each with scan steps, swaps and a final pivot move where needed,
// dropping out-of-bounds ranges; emission starts with a priming read, then gives one sorted
// key per cycle while the output is not stalled.
// Input is stalled from the last item until the final sorted key is loaded for output.
// Reset is synchronous, active low; no clearing pass is needed.
module iterative_quicksort_engine #(
    parameter int DEPTH     = iqs_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = iqs_pkg::KEY_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [KEY_WIDTH-1:0] i_key_in,
    input  logic                        i_last_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [KEY_WIDTH-1:0] o_key_out,
    output logic                        o_last_out,
    output logic                        o_overflow
);

    iqs_pkg::t_cmd cmd;
    iqs_pkg::t_sts sts;

    iqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last_in  (i_last_in),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    iqs_dpath #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_key_in    (i_key_in),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_key_out   (o_key_out),
        .o_last_out  (o_last_out),
        .o_overflow  (o_overflow)
    );

    // the last item of a set always closes the input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_in) |=> o_in_stall)
        else $error("input not stalled after last item");

    // input only closes because a set was completed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && i_last_in))
        else $error("input stalled without a last item");

    // a sorted key is never loaded over one still waiting at the output
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == iqs_pkg::OP_EMIT) |-> (!o_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

endmodule

// ----- tb/iqs_sort_checker.sv -----
// Checker for the quicksort engine: predicts the sorted output of each key set and compares.
`timescale 1ns / 1ps

module iqs_sort_checker #(
    parameter int DEPTH     = iqs_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = iqs_pkg::KEY_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic signed [KEY_WIDTH-1:0] i_key_in,
    input  logic                        i_last_in,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic signed [KEY_WIDTH-1:0] i_key_out,
    input  logic                        i_last_out,
    input  logic                        i_overflow,
    output int                          o_mismatches,
    output int                          o_pending
);

    typedef struct packed {
        logic signed [KEY_WIDTH-1:0] key;
        logic                        last;
        logic                        ovf;
    } t_sorted_key;

    logic signed [KEY_WIDTH-1:0] held_keys[$];
    logic                        keys_dropped;
    t_sorted_key                 sorted_q[$];
    int                          mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic flag_mismatch(input string what, input t_sorted_key want,
                                 input t_sorted_key got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected key %0d last %0b ovf %0b, got key %0d last %0b ovf %0b",
                     $realtime, what, want.key, want.last, want.ovf,
                     got.key, got.last, got.ovf);
    endtask

    // End of a set: sort the held keys ascending and queue one expected item per key.
    task automatic release_set();
        logic signed [KEY_WIDTH-1:0] ordered[DEPTH];
        logic signed [KEY_WIDTH-1:0] moving;
        t_sorted_key                 entry;
        int                          n;
        int                          p;
        n = held_keys.size();
        for (int i = 0; i < n; i++)
            ordered[i] = held_keys[i];
        for (int i = 1; i < n; i++) begin
            moving = ordered[i];
            p = i;
            while (p > 0 && ordered[p-1] > moving) begin
                ordered[p] = ordered[p-1];
                p--;
            end
            ordered[p] = moving;
        end
        for (int i = 0; i < n; i++) begin
            entry.key  = ordered[i];
            entry.last = (i == n - 1);
            entry.ovf  = keys_dropped;
            sorted_q.push_back(entry);
        end
        held_keys.delete();
        keys_dropped = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_sorted_key got;
        t_sorted_key want;
        if (!i_rst_n) begin
            held_keys.delete();
            sorted_q.delete();
            keys_dropped = 1'b0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.key  = i_key_out;
                got.last = i_last_out;
                got.ovf  = i_overflow;
                if (sorted_q.size() == 0) begin
                    want = '0;
                    flag_mismatch("unexpected output item", want, got);
                end else begin
                    want = sorted_q.pop_front();
                    if (got.key !== want.key || got.last !== want.last || got.ovf !== want.ovf)
                        flag_mismatch("output mismatch", want, got);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                // a full store drops the key but still honours its last flag
                if (held_keys.size() < DEPTH)
                    held_keys.push_back(i_key_in);
                else
                    keys_dropped = 1'b1;
                if (i_last_in)
                    release_set();
            end
        end
        o_pending <= sorted_q.size();
    end

endmodule

// ----- tb/tb_iterative_quicksort_engine.sv -----
// Testbench top for the quicksort engine: clock, reset, key sets, output stalls and verdict.
`timescale 1ns / 1ps

module tb_iterative_quicksort_engine;

    localparam int DEPTH      = iqs_pkg::DEPTH_DEF;
    localparam int KW         = iqs_pkg::KEY_WIDTH_DEF;
    localparam int IDLE_LIMIT = 40000;
    localparam int N_DIRECTED = 24;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [KW-1:0] key_in;
    logic                 last_in;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [KW-1:0] key_out;
    logic                 last_out;
    logic                 overflow;
    int                   mismatches;
    int                   pending;
    int                   idle_cycles = 0;
    int                   stall_left = 0;
    bit                   burst;

    iterative_quicksort_engine #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_key_in    (key_in),
        .i_last_in   (last_in),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_key_out   (key_out),
        .o_last_out  (last_out),
        .o_overflow  (overflow)
    );

    iqs_sort_checker #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KW)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_key_in     (key_in),
        .i_last_in    (last_in),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_key_out    (key_out),
        .i_last_out   (last_out),
        .i_overflow   (overflow),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 12)
            return 0;
        else if (roll < 18)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // full range, a narrow band around zero for duplicates, or an extreme
    function automatic logic signed [KW-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return KW'($urandom);
        else if (roll < 8)
            return KW'(int'($urandom_range(0, 8)) - 4);
        else
            case ($urandom_range(0, 3))
                0:       return {1'b1, {(KW-1){1'b0}}};
                1:       return {1'b0, {(KW-1){1'b1}}};
                2:       return '1;
                default: return '0;
            endcase
    endfunction

    task automatic send_key(input logic signed [KW-1:0] k, input logic l);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        key_in   = k;
        last_in  = l;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    // receiver: stretches without stall, short stalls and the odd long one
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            case ($urandom_range(0, 19))
                0: begin
                    out_stall  = 1'b1;
                    stall_left = $urandom_range(20, 60);
                end
                1, 2, 3, 4, 5: begin
                    out_stall  = 1'b1;
                    stall_left = $urandom_range(1, 3);
                end
                default: begin
                    out_stall  = 1'b0;
                    stall_left = $urandom_range(1, 20);
                end
            endcase
        end
        stall_left--;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_iterative_quicksort_engine: done, errors");
                $finish;
            end
        end
    end

    initial begin
        logic [KW-1:0] dir_keys[N_DIRECTED];
        bit            dir_last[N_DIRECTED];
        int            set_idx;
        int            set_len;
        int            random_items;

        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        key_in      = '0;
        last_in     = 1'b0;
        burst       = 1'b0;

        // single key; pair at both extremes; mixed extremes and bit patterns;
        // all equal; already ascending; descending
        dir_keys = '{16'h7fff,
                     16'h7fff, 16'h8000,
                     16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'h7fff, 16'h5555, 16'haaaa,
                     16'h0007, 16'h0007, 16'h0007, 16'h0007,
                     16'hfffd, 16'hfffe, 16'hffff, 16'h0000, 16'h0001,
                     16'h0004, 16'h0003, 16'h0002, 16'h0001, 16'h0000};
        foreach (dir_last[i])
            dir_last[i] = (i == 0 || i == 2 || i == 9 || i == 13 || i == 18 || i == 23);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_keys[i])
            send_key(dir_keys[i], dir_last[i]);

        // first a set that fills the store exactly, then one whose last two keys
        // are dropped (the final one carrying the last flag), then mostly small sets
        set_idx      = 0;
        random_items = 0;
        while (random_items < 250 - N_DIRECTED) begin
            if (set_idx == 0)
                set_len = DEPTH;
            else if (set_idx == 1)
                set_len = DEPTH + 2;
            else if ($urandom_range(0, 19) == 0)
                set_len = $urandom_range(13, 40);
            else
                set_len = $urandom_range(1, 12);
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < set_len; i++)
                send_key(pick_key(), i == set_len - 1);
            random_items += set_len;
            set_idx++;
        end
        in_valid = 1'b0;
        last_in  = 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_iterative_quicksort_engine: done, clean");
        else
            $display("tb_iterative_quicksort_engine: done, errors");
        $finish;
    end

endmodule
